/* sv/mce_pkg.sv */
package mce_pkg;

	localparam int MAX_CHORD_NOTES = 8;
	localparam int SLOT_W = 3;
	localparam int NOTE_W = 7;
	localparam int COUNT_W = 4;
	localparam int ROOTS = 128;
	localparam int SLOTS = ROOTS * (1 << SLOT_W);
	localparam int DATA_W = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 56;

	localparam logic [1:0] MIDI_NOTE_ON = 2'd0;
	localparam logic [1:0] MIDI_NOTE_OFF = 2'd1;
	localparam logic [1:0] MIDI_OTHER = 2'd2;
	localparam logic [1:0] MIDI_RESERVED = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_EXPAND_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_AUTO_MODE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_PITCH_CLASS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_MODE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_COUNT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_INTERVALS = 3'd5;

	localparam logic [3:0] SCALE_STEPS [0:5][0:6] = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10}
	};

	// 0 major, 1 minor, 2 diminished
	localparam logic [1:0] SCALE_QUALITY [0:5][0:6] = '{
		'{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2},
		'{2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0},
		'{2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1},
		'{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1},
		'{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0}
	};

	localparam logic [2:0] TRIAD_IVS [0:2][0:2] = '{
		'{3'd0, 3'd4, 3'd7},
		'{3'd0, 3'd3, 3'd7},
		'{3'd0, 3'd3, 3'd6}
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FWD,
		ST_CHORD,
		ST_RELEASE
	} state_t;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_CHORD,
		MODE_RELEASE
	} mode_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic emit_fwd;
		logic emit_on;
		logic emit_rel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic fwd_last;
		logic on_last;
		logic rel_last;
		mode_t mode;
	} sts_t;

	function automatic logic [3:0] mod12_small(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		for (int k = 1; k <= 5; k++) begin
			if (v >= 7'(12 * k)) begin
				r = v - 7'(12 * k);
			end
		end
		return r[3:0];
	endfunction

	function automatic logic [1:0] triad_quality(input logic [2:0] s, input logic [3:0] pc);
		logic [2:0] deg;
		deg = 3'd0;
		for (int i = 1; i < 7; i++) begin
			if (SCALE_STEPS[s][i] <= pc) begin
				deg = 3'(i);
			end
		end
		return SCALE_QUALITY[s][deg];
	endfunction

endpackage

/* sv/midi_chord_expander.sv */
// first result: the event is registered on acceptance, decided in ST_DECIDE, then loaded
// into the output register; a new input is taken only after the last result of the current
// one, the controller emitting one result per cycle, unless the receiver stalls, through the single output register
// reset: arst_n clears configuration, held-chord valid bits and the output valid;
// no clearing pass, the block accepts input right after reset
module midi_chord_expander
	import mce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [DATA_W-1:0]      s_axis_tdata,  // command, channel, note, velocity
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,  // out_command, out_channel, out_note, out_velocity
	output logic                   m_axis_tlast
);

	cmd_t cmd;
	sts_t sts;

	mce_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	mce_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tdata (s_axis_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

/* sv/mce_ram.sv */
module mce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/mce_ctrl.sv */
module mce_ctrl
	import mce_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_axis_tvalid,
	output logic   s_axis_tready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_FWD;
			end
			ST_FWD: begin
				if (sts.out_free) begin
					if (sts.fwd_last) begin
						state_d = ST_IDLE;
					end else if (sts.mode == MODE_CHORD) begin
						state_d = ST_CHORD;
					end else begin
						state_d = ST_RELEASE;
					end
				end
			end
			ST_CHORD: begin
				if (sts.out_free && sts.on_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RELEASE: begin
				if (sts.out_free && sts.rel_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.load = s_axis_tvalid;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
			end
			ST_FWD: begin
				cmd.emit_fwd = sts.out_free;
			end
			ST_CHORD: begin
				cmd.emit_on = sts.out_free;
			end
			ST_RELEASE: begin
				cmd.emit_rel = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/mce_dp.sv */
module mce_dp
	import mce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [DATA_W-1:0]      s_axis_tdata,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [DATA_W-1:0]      m_axis_tdata,
	output logic                   m_axis_tlast
);

	logic                  en_q;
	logic                  auto_q;
	logic [3:0]            key_q;
	logic [2:0]            scale_q;
	logic [3:0]            mcount_q;
	logic [CFG_DATA_W-1:0] ivs_q;

	logic [1:0]        cmd_q;
	logic [3:0]        ch_q;
	logic [NOTE_W-1:0] root_q;
	logic [NOTE_W-1:0] vel_q;

	mode_t              mode_q;
	logic [7:0]         mask_q;
	logic [1:0]         kind_q;
	logic [COUNT_W-1:0] held_q;
	logic [SLOT_W-1:0]  idx_q;
	logic [COUNT_W-1:0] store_q;
	logic [ROOTS-1:0]   valid_q;

	logic              out_valid_q;
	logic [1:0]        out_cmd_q;
	logic [3:0]        out_ch_q;
	logic [NOTE_W-1:0] out_note_q;
	logic [NOTE_W-1:0] out_vel_q;
	logic              out_last_q;

	logic [COUNT_W-1:0] cnt_rd;
	logic [NOTE_W-1:0]  note_rd;
	logic               store_we;
	logic [SLOT_W-1:0]  idx_next;

	logic [1:0]         in_cmd;
	logic [3:0]         mcs;
	logic               expand;
	logic               is_on;
	logic               is_off;
	logic [7:0]         mask_d;
	logic [6:0]         pc_sum;
	logic [2:0]         scale_sat;
	logic [1:0]         kind_d;
	logic [2:0]         sel;
	logic [NOTE_W-1:0]  iv;
	logic [NOTE_W:0]    sum;
	logic [NOTE_W-1:0]  chord_note;
	logic [7:0]         mask_rest;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			auto_q <= 1'b0;
			key_q <= '0;
			scale_q <= '0;
			mcount_q <= '0;
			ivs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPAND_ENABLE:    en_q <= cfg_wdata[0];
				REG_AUTO_MODE:        auto_q <= cfg_wdata[0];
				REG_KEY_PITCH_CLASS:  key_q <= cfg_wdata[3:0];
				REG_SCALE_MODE:       scale_q <= cfg_wdata[2:0];
				REG_MANUAL_COUNT:     mcount_q <= cfg_wdata[3:0];
				REG_MANUAL_INTERVALS: ivs_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_cmd = (s_axis_tdata[1:0] == MIDI_RESERVED) ? MIDI_OTHER : s_axis_tdata[1:0];

	// decision for the current event
	always_comb begin
		mcs = (mcount_q > 4'd8) ? 4'd8 : mcount_q;
		expand = en_q && (auto_q || (mcs > 4'd1));
		is_on = (cmd_q == MIDI_NOTE_ON) && (vel_q != '0);
		is_off = (cmd_q == MIDI_NOTE_OFF) || ((cmd_q == MIDI_NOTE_ON) && (vel_q == '0));
		scale_sat = (scale_q > 3'd5) ? 3'd5 : scale_q;
		pc_sum = {2'b00, root_q[6:4], 2'b00} + {3'b000, root_q[3:0]} + 7'd24
			- {3'b000, key_q};
		kind_d = triad_quality(scale_sat, mod12_small(pc_sum));
		if (auto_q) begin
			mask_d = 8'b0000_0110;
		end else begin
			for (int i = 0; i < 8; i++) begin
				mask_d[i] = (4'(i) < mcs) && (ivs_q[7*i +: 7] != '0);
			end
		end
	end

	// chord note generation
	always_comb begin
		sel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = 3'(i);
			end
		end
		if (auto_q) begin
			iv = {4'b0000, TRIAD_IVS[kind_q][sel[1:0]]};
		end else begin
			iv = ivs_q[7*sel +: 7];
		end
		sum = {1'b0, root_q} + {1'b0, iv};
		chord_note = sum[NOTE_W] ? 7'd127 : sum[NOTE_W-1:0];
		mask_rest = mask_q & (mask_q - 8'd1);
	end

	assign store_we = cmd.emit_on && (store_q < COUNT_W'(MAX_CHORD_NOTES));
	assign idx_next = cmd.emit_rel ? idx_q + 3'd1 : idx_q;

	always_comb begin
		sts.out_free = !out_valid_q || m_axis_tready;
		sts.mode = mode_q;
		sts.on_last = (mask_rest == '0);
		sts.rel_last = ({1'b0, idx_q} + 4'd1) == held_q;
		sts.fwd_last = (mode_q == MODE_PASS) || ((mode_q == MODE_CHORD) && (mask_q == '0))
			|| ((mode_q == MODE_RELEASE) && (held_q == '0));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd;
			ch_q <= s_axis_tdata[5:2];
			root_q <= s_axis_tdata[12:6];
			vel_q <= s_axis_tdata[19:13];
		end
		if (cmd.decide) begin
			mask_q <= mask_d;
			kind_q <= kind_d;
			held_q <= valid_q[root_q] ? cnt_rd : '0;
			store_q <= '0;
			if (expand && is_on) begin
				mode_q <= MODE_CHORD;
			end else if (expand && is_off) begin
				mode_q <= MODE_RELEASE;
			end else begin
				mode_q <= MODE_PASS;
			end
		end
		if (cmd.emit_on) begin
			mask_q <= mask_rest;
		end
		if (store_we) begin
			store_q <= store_q + 4'd1;
		end
		idx_q <= cmd.decide ? '0 : idx_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.decide && expand && (is_on || is_off)) begin
			valid_q[root_q] <= 1'b0;
		end else if (store_we) begin
			valid_q[root_q] <= 1'b1;
		end
	end

	mce_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(ROOTS)
	) u_count_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(root_q),
		.wdata(store_q + 4'd1),
		.raddr(s_axis_tdata[12:6]),
		.rdata(cnt_rd)
	);

	mce_ram #(
		.WIDTH(NOTE_W),
		.DEPTH(SLOTS)
	) u_note_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr({root_q, store_q[SLOT_W-1:0]}),
		.wdata(chord_note),
		.raddr({root_q, idx_next}),
		.rdata(note_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_fwd || cmd.emit_on || cmd.emit_rel) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_fwd) begin
			out_cmd_q <= cmd_q;
			out_ch_q <= ch_q;
			out_note_q <= root_q;
			out_vel_q <= vel_q;
			out_last_q <= sts.fwd_last;
		end else if (cmd.emit_on) begin
			out_cmd_q <= MIDI_NOTE_ON;
			out_ch_q <= ch_q;
			out_note_q <= chord_note;
			out_vel_q <= vel_q;
			out_last_q <= sts.on_last;
		end else if (cmd.emit_rel) begin
			out_cmd_q <= MIDI_NOTE_OFF;
			out_ch_q <= ch_q;
			out_note_q <= note_rd;
			out_vel_q <= '0;
			out_last_q <= sts.rel_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, out_vel_q, out_note_q, out_ch_q, out_cmd_q};
	assign m_axis_tlast = out_last_q;

endmodule

/* sv/mce_checker.sv */
module mce_checker
	import mce_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// one event in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an event is in flight");

	// no new event until the final result of the current one is out
	a_no_accept_mid_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready before final result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output changed");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != MIDI_RESERVED)
		else $error("output command code three");

endmodule

bind midi_chord_expander mce_checker u_mce_checker (.*);

/* test/midi_chord_expander_checker.sv */
`timescale 1ns / 100ps
module midi_chord_expander_checker
	import mce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [DATA_W-1:0]      s_axis_tdata,  // command, channel, note, velocity
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [DATA_W-1:0]      m_axis_tdata,  // out_command, out_channel, out_note, out_velocity
	input  logic                   m_axis_tlast,
	output int                     mismatches,
	output int                     pending,
	output int                     events_seen,
	output int                     results_seen,
	output int                     chord_notes,
	output int                     released_notes
);

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] channel;
		logic [6:0] note;
		logic [6:0] velocity;
		logic       last;
	} midi_result_t;

	localparam logic [3:0] STEP_TABLE [0:5][0:6] = '{
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
		'{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
		'{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
		'{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10}
	};

	// major, minor, diminished
	localparam logic [1:0] QUALITY_TABLE [0:5][0:6] = '{
		'{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2},
		'{2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0, 2'd0},
		'{2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0},
		'{2'd1, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1},
		'{2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1},
		'{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd1, 2'd0}
	};

	localparam logic [2:0] TRIAD_TABLE [0:2][0:2] = '{
		'{3'd0, 3'd4, 3'd7},
		'{3'd0, 3'd3, 3'd7},
		'{3'd0, 3'd3, 3'd6}
	};

	logic        cfg_expand = 1'b0;
	logic        cfg_auto = 1'b0;
	logic [3:0]  cfg_key = '0;
	logic [2:0]  cfg_scale = '0;
	logic [3:0]  cfg_count = '0;
	logic [55:0] cfg_intervals = '0;

	logic [3:0] held_count [128];
	logic [6:0] held_notes [128][8];

	midi_result_t expected_events [$];

	initial begin
		mismatches = 0;
		pending = 0;
		events_seen = 0;
		results_seen = 0;
		chord_notes = 0;
		released_notes = 0;
	end

	function automatic int unsigned chord_kind_for(input logic [6:0] root);
		int unsigned s;
		int unsigned pc;
		int unsigned best;
		int unsigned deg;
		int unsigned diff;
		s = (cfg_scale > 3'd5) ? 5 : cfg_scale;
		pc = (root + 24 - cfg_key) % 12;
		best = 12;
		deg = 0;
		for (int i = 0; i < 7; i++) begin
			diff = (pc + 12 - STEP_TABLE[s][i]) % 12;
			if (diff < best) begin
				best = diff;
				deg = i;
			end
		end
		return QUALITY_TABLE[s][deg];
	endfunction

	task automatic queue_result(input logic [1:0] cmd, input logic [3:0] ch,
		input logic [6:0] note, input logic [6:0] vel);
		midi_result_t r;
		r.command = cmd;
		r.channel = ch;
		r.note = note;
		r.velocity = vel;
		r.last = 1'b0;
		expected_events.insert(expected_events.size(), r);
	endtask

	task automatic harmonize_event(input logic [1:0] cmd_in, input logic [3:0] ch,
		input logic [6:0] root, input logic [6:0] vel);
		logic [1:0] cmd;
		int unsigned mcount;
		int unsigned total;
		int unsigned kind;
		int unsigned cnt;
		int unsigned iv;
		int unsigned pitch;
		bit note_on;
		bit note_off;
		cmd = (cmd_in > MIDI_OTHER) ? MIDI_OTHER : cmd_in;
		mcount = (cfg_count > 4'd8) ? 8 : cfg_count;
		note_on = (cmd == MIDI_NOTE_ON) && (vel != '0);
		note_off = (cmd == MIDI_NOTE_OFF) || (cmd == MIDI_NOTE_ON && vel == '0);
		queue_result(cmd, ch, root, vel);
		if (cfg_expand && (cfg_auto || mcount > 1)) begin
			if (note_on) begin
				cnt = 0;
				total = cfg_auto ? 3 : mcount;
				kind = chord_kind_for(root);
				for (int i = 0; i < total; i++) begin
					if (cfg_auto) begin
						iv = TRIAD_TABLE[kind][i];
					end else begin
						iv = 7'(cfg_intervals >> (7 * i));
					end
					if (iv != 0) begin
						pitch = root + iv;
						if (pitch > 127) begin
							pitch = 127;
						end
						queue_result(MIDI_NOTE_ON, ch, 7'(pitch), vel);
						chord_notes++;
						if (cnt < MAX_CHORD_NOTES) begin
							held_notes[root][cnt] = 7'(pitch);
							cnt++;
						end
					end
				end
				held_count[root] = 4'(cnt);
			end else if (note_off) begin
				for (int i = 0; i < held_count[root]; i++) begin
					queue_result(MIDI_NOTE_OFF, ch, held_notes[root][i], '0);
					released_notes++;
				end
				held_count[root] = '0;
			end
		end
		expected_events[expected_events.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		midi_result_t got;
		midi_result_t want;
		if (!arst_n) begin
			cfg_expand = 1'b0;
			cfg_auto = 1'b0;
			cfg_key = '0;
			cfg_scale = '0;
			cfg_count = '0;
			cfg_intervals = '0;
			foreach (held_count[i]) held_count[i] = '0;
			expected_events.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPAND_ENABLE: cfg_expand = cfg_wdata[0];
					REG_AUTO_MODE: cfg_auto = cfg_wdata[0];
					REG_KEY_PITCH_CLASS: cfg_key = cfg_wdata[3:0];
					REG_SCALE_MODE: cfg_scale = cfg_wdata[2:0];
					REG_MANUAL_COUNT: cfg_count = cfg_wdata[3:0];
					REG_MANUAL_INTERVALS: cfg_intervals = cfg_wdata[55:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				events_seen++;
				harmonize_event(s_axis_tdata[1:0], s_axis_tdata[5:2],
					s_axis_tdata[12:6], s_axis_tdata[19:13]);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.command = m_axis_tdata[1:0];
				got.channel = m_axis_tdata[5:2];
				got.note = m_axis_tdata[12:6];
				got.velocity = m_axis_tdata[19:13];
				got.last = m_axis_tlast;
				if (expected_events.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected transaction cmd %0d ch %0d note %0d vel %0d last %0b",
							$time, got.command, got.channel, got.note, got.velocity, got.last);
					end
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (got.command !== want.command || got.channel !== want.channel ||
						got.note !== want.note || got.velocity !== want.velocity ||
						got.last !== want.last) begin
						if (mismatches < 10) begin
							$display("%0t: expected cmd %0d ch %0d note %0d vel %0d last %0b",
								$time, want.command, want.channel, want.note, want.velocity,
								want.last);
							$display("%0t:      got cmd %0d ch %0d note %0d vel %0d last %0b",
								$time, got.command, got.channel, got.note, got.velocity,
								got.last);
						end
						mismatches++;
					end
				end
			end
			pending = expected_events.size();
		end
	end

endmodule

/* test/midi_chord_expander_tb.sv */
`timescale 1ns / 100ps
module midi_chord_expander_tb;
	import mce_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PHASES = 10;
	localparam int EVENTS_PER_PHASE = 50;

	typedef struct {
		logic        expand;
		logic        auto_on;
		logic [3:0]  key;
		logic [2:0]  scale;
		logic [3:0]  count;
		logic [55:0] intervals;
	} harmony_setup_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [DATA_W-1:0]      s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [DATA_W-1:0]      m_axis_tdata;
	logic                   m_axis_tlast;

	int mismatches;
	int pending;
	int events_seen;
	int results_seen;
	int chord_notes;
	int released_notes;
	int setups_applied = 0;
	int cycle_count = 0;

	logic [6:0]  stall_phase = '0;
	logic [31:0] stall_mask = '1;
	logic [6:0]  sounding [$];

	midi_chord_expander u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	midi_chord_expander_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.pending        (pending),
		.events_seen    (events_seen),
		.results_seen   (results_seen),
		.chord_notes    (chord_notes),
		.released_notes (released_notes)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stalls on a repeating pattern from a 32-bit mask, reloaded whenever the 7-bit phase counter wraps
	always @(posedge clk) begin
		stall_phase <= stall_phase + 7'd1;
		if (stall_phase == '0) begin
			stall_mask <= ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'd1);
		end
		m_axis_tready <= stall_mask[stall_phase[4:0]];
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
	endtask

	task automatic apply_setup(input harmony_setup_t h);
		write_reg(REG_EXPAND_ENABLE, CFG_DATA_W'(h.expand));
		write_reg(REG_AUTO_MODE, CFG_DATA_W'(h.auto_on));
		write_reg(REG_KEY_PITCH_CLASS, CFG_DATA_W'(h.key));
		write_reg(REG_SCALE_MODE, CFG_DATA_W'(h.scale));
		write_reg(REG_MANUAL_COUNT, CFG_DATA_W'(h.count));
		write_reg(REG_MANUAL_INTERVALS, CFG_DATA_W'(h.intervals));
		cfg_we <= 1'b0;
		setups_applied++;
	endtask

	task automatic send_event(input logic [1:0] cmd, input logic [3:0] ch,
		input logic [6:0] note, input logic [6:0] vel);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, vel, note, ch, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic harmony_setup_t random_setup();
		harmony_setup_t h;
		h.expand = ($urandom_range(0, 7) != 0);
		h.auto_on = 1'($urandom);
		h.key = 4'($urandom);
		h.scale = 3'($urandom);
		h.count = 4'($urandom);
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 5))
				0: h.intervals[7*i +: 7] = '0;
				1: h.intervals[7*i +: 7] = 7'($urandom);
				default: h.intervals[7*i +: 7] = 7'($urandom_range(1, 24));
			endcase
		end
		return h;
	endfunction

	// mostly paired note on / note off on the same root, some noise
	task automatic play_random_event();
		int pick;
		int idx;
		logic [1:0] cmd;
		logic [6:0] root;
		logic [6:0] vel;
		pick = $urandom_range(0, 99);
		if (sounding.size() > 16) begin
			pick = 50;
		end
		cmd = 2'($urandom);
		root = 7'($urandom);
		vel = 7'($urandom);
		if (pick < 40) begin
			cmd = MIDI_NOTE_ON;
			if ($urandom_range(0, 3) != 0) begin
				root = 7'($urandom_range(36, 96));
			end
			vel = 7'($urandom_range(1, 127));
			sounding.insert(sounding.size(), root);
		end else if (pick < 75 && sounding.size() > 0) begin
			idx = $urandom_range(0, sounding.size() - 1);
			root = sounding[idx];
			sounding.delete(idx);
			if ($urandom_range(0, 4) == 0) begin
				cmd = MIDI_NOTE_ON;
				vel = '0;
			end else begin
				cmd = MIDI_NOTE_OFF;
			end
		end else if (pick < 88) begin
			cmd = $urandom_range(0, 1) ? MIDI_OTHER : MIDI_RESERVED;
		end
		send_event(cmd, 4'($urandom), root, vel);
	endtask

	task automatic random_traffic(input int total);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < total) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && sent < total; k++) begin
				play_random_event();
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		harmony_setup_t h;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset values
		send_event(MIDI_NOTE_ON, 4'd0, 7'd60, 7'd100);
		send_event(MIDI_RESERVED, 4'hf, 7'h7f, 7'h7f);
		drain();

		// expansion off with everything else set
		apply_setup('{1'b0, 1'b1, 4'd0, 3'd0, 4'd8, '1});
		send_event(MIDI_NOTE_ON, 4'd3, 7'd64, 7'd127);
		send_event(MIDI_NOTE_OFF, 4'd3, 7'd64, 7'd0);
		drain();

		// c major triads
		apply_setup('{1'b1, 1'b1, 4'd0, 3'd0, 4'd0, 56'd0});
		send_event(MIDI_NOTE_ON, 4'd1, 7'd60, 7'd90);
		send_event(MIDI_NOTE_ON, 4'd1, 7'd62, 7'd90);
		send_event(MIDI_NOTE_ON, 4'd1, 7'd71, 7'd90);
		send_event(MIDI_NOTE_ON, 4'd1, 7'd61, 7'd90);
		send_event(MIDI_NOTE_ON, 4'd2, 7'd127, 7'd1);
		send_event(MIDI_NOTE_OFF, 4'd1, 7'd60, 7'd64);
		send_event(MIDI_NOTE_ON, 4'd1, 7'd62, 7'd0);
		send_event(MIDI_NOTE_ON, 4'd1, 7'd71, 7'd50);
		send_event(MIDI_NOTE_OFF, 4'd5, 7'd71, 7'd0);
		send_event(MIDI_NOTE_OFF, 4'd1, 7'd61, 7'd0);
		send_event(MIDI_NOTE_OFF, 4'd1, 7'd30, 7'd0);
		send_event(MIDI_OTHER, 4'd9, 7'd60, 7'd5);
		drain();

		// out-of-range key and scale codes
		apply_setup('{1'b1, 1'b1, 4'd15, 3'd7, 4'd0, 56'd0});
		send_event(MIDI_NOTE_ON, 4'd0, 7'd0, 7'd127);
		send_event(MIDI_NOTE_OFF, 4'd0, 7'd0, 7'd0);
		drain();

		// full manual list, every note landing on 127
		apply_setup('{1'b1, 1'b0, 4'd0, 3'd0, 4'd15, '1});
		send_event(MIDI_NOTE_ON, 4'd7, 7'd0, 7'd127);
		send_event(MIDI_NOTE_OFF, 4'd7, 7'd0, 7'd0);
		drain();

		// manual list with zero gaps, then a single interval
		apply_setup('{1'b1, 1'b0, 4'd0, 3'd0, 4'd8,
			{7'd127, 7'd100, 7'd0, 7'd12, 7'd7, 7'd0, 7'd4, 7'd0}});
		send_event(MIDI_NOTE_ON, 4'd4, 7'd60, 7'd64);
		drain();
		apply_setup('{1'b1, 1'b0, 4'd0, 3'd0, 4'd1, '1});
		send_event(MIDI_NOTE_OFF, 4'd4, 7'd60, 7'd0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			h = random_setup();
			if (p == 0) begin
				h.expand = 1'b1;
				h.auto_on = 1'b1;
			end else if (p == 1) begin
				h.expand = 1'b1;
				h.auto_on = 1'b0;
				h.count = 4'd8;
			end
			apply_setup(h);
			random_traffic(EVENTS_PER_PHASE);
			drain();
		end

		repeat (16) @(posedge clk);
		@(negedge clk);
		$display("%0d events sent under %0d register settings, %0d results checked",
			events_seen, setups_applied, results_seen);
		$display("%0d chord notes generated, %0d held notes released",
			chord_notes, released_notes);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/mce_pkg.sv
sv/mce_ram.sv
sv/mce_ctrl.sv
sv/mce_dp.sv
sv/midi_chord_expander.sv
sv/mce_checker.sv
test/midi_chord_expander_checker.sv
test/midi_chord_expander_tb.sv
